// File: rtl/hgc_pkg.sv
// Shared types and constants of the heater guard controller.
`default_nettype none

package hgc_pkg;

    localparam int CODE_W   = 10;
    localparam int TIME_W   = 32;
    localparam int BLINK_W  = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CODE_W-1:0]  CAB_ON_MAX_RST    = 10'd457;
    localparam logic [CODE_W-1:0]  ROOM_DELTA_RST    = 10'd9;
    localparam logic [CODE_W-1:0]  ROOM_LIMIT_RST    = 10'd437;
    localparam logic [CODE_W-1:0]  SENSOR_LOW_RST    = 10'd172;
    localparam logic [CODE_W-1:0]  SENSOR_HIGH_RST   = 10'd703;
    localparam logic [TIME_W-1:0]  ROOM_PERIOD_RST   = 32'd60000;
    localparam logic [TIME_W-1:0]  CAB_PERIOD_RST    = 32'd30000;
    localparam logic [BLINK_W-1:0] BLINK_PERIOD_RST  = 16'd500;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAB_ON_MAX   = 3'd0,
        CFG_ROOM_DELTA   = 3'd1,
        CFG_ROOM_LIMIT   = 3'd2,
        CFG_SENSOR_LOW   = 3'd3,
        CFG_SENSOR_HIGH  = 3'd4,
        CFG_ROOM_PERIOD  = 3'd5,
        CFG_CAB_PERIOD   = 3'd6,
        CFG_BLINK_PERIOD = 3'd7
    } cfg_idx_e;

    typedef struct packed {
        logic [CODE_W-1:0]  cab_on_max_code;
        logic [CODE_W-1:0]  room_delta_code;
        logic [CODE_W-1:0]  room_limit_code;
        logic [CODE_W-1:0]  sensor_low_code;
        logic [CODE_W-1:0]  sensor_high_code;
        logic [TIME_W-1:0]  room_period_ms;
        logic [TIME_W-1:0]  cab_period_ms;
        logic [BLINK_W-1:0] blink_period_ms;
    } cfg_t;

    typedef struct packed {
        logic room_heat;
        logic cabinet_heat;
        logic sensor_error;
        logic report_now;
    } flags_t;

endpackage

`default_nettype wire

// File: rtl/heater_guard_controller.sv
// A beat accepted on s_ goes to the input register, then the result register, and so to m_.
// One beat per cycle unless m_ready stalls; per-beat work is one pass between the two registers.
// The averaging rings are memories with a registered read that is prefetched one beat ahead.
// Reset (aresetn, synchronous, active low) clears control, sums, timers and config to defaults.
// Ring contents are not cleared: a fill flag reads unwritten entries as zero until the first wrap.
`default_nettype none

module heater_guard_controller #(
    parameter int AVG_DEPTH        = 16,
    parameter int REPORT_PERIOD_MS = 5000,
    parameter int SAMPLE_BITS      = 10
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [hgc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [hgc_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [hgc_pkg::TIME_W-1:0]        s_now_ms,
    input  wire logic [SAMPLE_BITS-1:0]            s_in_air_sample,
    input  wire logic [SAMPLE_BITS-1:0]            s_out_air_sample,
    input  wire logic [SAMPLE_BITS-1:0]            s_cabinet_sample,
    input  wire logic                              s_test_button,

    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_room_heat,
    output logic                                   m_cabinet_heat,
    output logic                                   m_sensor_error,
    output logic                                   m_report_now,
    output logic [hgc_pkg::CODE_W-1:0]             m_avg_in_code,
    output logic [hgc_pkg::CODE_W-1:0]             m_avg_out_code,
    output logic [hgc_pkg::CODE_W-1:0]             m_avg_cab_code
);

    localparam int IDX_W = $clog2(AVG_DEPTH);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(AVG_DEPTH - 1);

    hgc_pkg::cfg_t   cfg;
    hgc_pkg::flags_t flags;

    // input stage
    logic                       in_valid_reg;
    logic [hgc_pkg::TIME_W-1:0] now_reg;
    logic [SAMPLE_BITS-1:0]     in_air_reg, out_air_reg, cab_reg;
    logic                       button_reg;

    // result stage
    logic                       out_valid_reg;
    hgc_pkg::flags_t            flags_reg;
    logic [hgc_pkg::CODE_W-1:0] avg_in_out_reg, avg_out_out_reg, avg_cab_out_reg;

    logic [IDX_W-1:0]       idx_reg, idx_next, rd_idx;
    logic                   filled_reg;
    logic                   advance;
    logic [SAMPLE_BITS-1:0] avg_in, avg_out, avg_cab;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign idx_next  = (idx_reg == IDX_LAST) ? '0 : idx_reg + 1'b1;
    assign rd_idx    = advance ? idx_next : idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            filled_reg    <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (advance) begin
                idx_reg <= idx_next;
                if (idx_reg == IDX_LAST) begin
                    filled_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            now_reg     <= s_now_ms;
            in_air_reg  <= s_in_air_sample;
            out_air_reg <= s_out_air_sample;
            cab_reg     <= s_cabinet_sample;
            button_reg  <= s_test_button;
        end
        if (advance) begin
            flags_reg       <= flags;
            avg_in_out_reg  <= hgc_pkg::CODE_W'(avg_in);
            avg_out_out_reg <= hgc_pkg::CODE_W'(avg_out);
            avg_cab_out_reg <= hgc_pkg::CODE_W'(avg_cab);
        end
    end

    hgc_regs u_regs (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    hgc_chan_avg #(
        .AVG_DEPTH   (AVG_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .IDX_W       (IDX_W)
    ) u_avg_in (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .sample  (in_air_reg),
        .wr_idx  (idx_reg),
        .rd_idx  (rd_idx),
        .filled  (filled_reg),
        .avg     (avg_in)
    );

    hgc_chan_avg #(
        .AVG_DEPTH   (AVG_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .IDX_W       (IDX_W)
    ) u_avg_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .sample  (out_air_reg),
        .wr_idx  (idx_reg),
        .rd_idx  (rd_idx),
        .filled  (filled_reg),
        .avg     (avg_out)
    );

    hgc_chan_avg #(
        .AVG_DEPTH   (AVG_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .IDX_W       (IDX_W)
    ) u_avg_cab (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .sample  (cab_reg),
        .wr_idx  (idx_reg),
        .rd_idx  (rd_idx),
        .filled  (filled_reg),
        .avg     (avg_cab)
    );

    hgc_ctrl #(
        .SAMPLE_BITS      (SAMPLE_BITS),
        .REPORT_PERIOD_MS (REPORT_PERIOD_MS)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .now_ms      (now_reg),
        .test_button (button_reg),
        .avg_in      (avg_in),
        .avg_out     (avg_out),
        .avg_cab     (avg_cab),
        .cfg         (cfg),
        .flags       (flags)
    );

    assign m_valid        = out_valid_reg;
    assign m_room_heat    = flags_reg.room_heat;
    assign m_cabinet_heat = flags_reg.cabinet_heat;
    assign m_sensor_error = flags_reg.sensor_error;
    assign m_report_now   = flags_reg.report_now;
    assign m_avg_in_code  = avg_in_out_reg;
    assign m_avg_out_code = avg_out_out_reg;
    assign m_avg_cab_code = avg_cab_out_reg;

    // a processed beat always lands in the result register
    a_advance_out: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("processed beat did not reach result register");

    // ring pointer stays inside the ring for non power of two depths too
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg <= IDX_LAST)
        else $error("ring index out of range");

    // an empty input stage never stalls the upstream side
    a_in_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("input stage empty but not ready");

    // report never fires on a button beat
    a_no_report_test: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && button_reg) |=> !m_report_now)
        else $error("report fired while test button held");

endmodule

`default_nettype wire

// File: rtl/hgc_regs.sv
// Configuration register file of the heater guard controller.
`default_nettype none

module hgc_regs (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             wr_en,
    input  wire logic [hgc_pkg::CFG_IDX_W-1:0]    wr_index,
    input  wire logic [hgc_pkg::CFG_DATA_W-1:0]   wr_data,
    output hgc_pkg::cfg_t                         cfg
);

    hgc_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cab_on_max_code  <= hgc_pkg::CAB_ON_MAX_RST;
            cfg_reg.room_delta_code  <= hgc_pkg::ROOM_DELTA_RST;
            cfg_reg.room_limit_code  <= hgc_pkg::ROOM_LIMIT_RST;
            cfg_reg.sensor_low_code  <= hgc_pkg::SENSOR_LOW_RST;
            cfg_reg.sensor_high_code <= hgc_pkg::SENSOR_HIGH_RST;
            cfg_reg.room_period_ms   <= hgc_pkg::ROOM_PERIOD_RST;
            cfg_reg.cab_period_ms    <= hgc_pkg::CAB_PERIOD_RST;
            cfg_reg.blink_period_ms  <= hgc_pkg::BLINK_PERIOD_RST;
        end else if (wr_en) begin
            unique case (hgc_pkg::cfg_idx_e'(wr_index))
                hgc_pkg::CFG_CAB_ON_MAX:   cfg_reg.cab_on_max_code  <= wr_data[hgc_pkg::CODE_W-1:0];
                hgc_pkg::CFG_ROOM_DELTA:   cfg_reg.room_delta_code  <= wr_data[hgc_pkg::CODE_W-1:0];
                hgc_pkg::CFG_ROOM_LIMIT:   cfg_reg.room_limit_code  <= wr_data[hgc_pkg::CODE_W-1:0];
                hgc_pkg::CFG_SENSOR_LOW:   cfg_reg.sensor_low_code  <= wr_data[hgc_pkg::CODE_W-1:0];
                hgc_pkg::CFG_SENSOR_HIGH:  cfg_reg.sensor_high_code <= wr_data[hgc_pkg::CODE_W-1:0];
                hgc_pkg::CFG_ROOM_PERIOD:  cfg_reg.room_period_ms   <= wr_data[hgc_pkg::TIME_W-1:0];
                hgc_pkg::CFG_CAB_PERIOD:   cfg_reg.cab_period_ms    <= wr_data[hgc_pkg::TIME_W-1:0];
                hgc_pkg::CFG_BLINK_PERIOD: cfg_reg.blink_period_ms  <= wr_data[hgc_pkg::BLINK_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: rtl/hgc_chan_avg.sv
// One ADC channel: sample ring memory, running sum and divide by depth.
`default_nettype none

module hgc_chan_avg #(
    parameter int AVG_DEPTH   = 16,
    parameter int SAMPLE_BITS = 10,
    parameter int IDX_W       = 4
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   advance,
    input  wire logic [SAMPLE_BITS-1:0] sample,
    input  wire logic [IDX_W-1:0]       wr_idx,
    input  wire logic [IDX_W-1:0]       rd_idx,
    input  wire logic                   filled,
    output logic      [SAMPLE_BITS-1:0] avg
);

    localparam int L_BITS = $clog2(AVG_DEPTH);
    localparam int SUM_W  = SAMPLE_BITS + L_BITS;
    localparam int SHIFT  = SUM_W + L_BITS;
    localparam int PROD_W = 2 * SUM_W + 1;
    // ceil(2^SHIFT / depth): exact quotient for every SUM_W-bit dividend
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << SHIFT) + AVG_DEPTH - 1) / AVG_DEPTH;
    localparam logic [SUM_W:0] RECIP = RECIP_FULL[SUM_W:0];

    logic [SAMPLE_BITS-1:0] ring_mem [AVG_DEPTH];
    logic [SAMPLE_BITS-1:0] rd_q_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [SUM_W-1:0]       sum_next;
    logic [SAMPLE_BITS-1:0] old_sample;
    logic [PROD_W-1:0]      prod;

    // rd_q_reg always holds the entry that the next beat overwrites
    always_ff @(posedge aclk) begin
        if (advance) begin
            ring_mem[wr_idx] <= sample;
        end
        rd_q_reg <= ring_mem[rd_idx];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else if (advance) begin
            sum_reg <= sum_next;
        end
    end

    always_comb begin
        old_sample = filled ? rd_q_reg : '0;
        sum_next   = sum_reg - SUM_W'(old_sample) + SUM_W'(sample);
        prod       = PROD_W'(sum_next) * PROD_W'(RECIP);
        avg        = prod[SHIFT +: SAMPLE_BITS];
    end

endmodule

`default_nettype wire

// File: rtl/hgc_ctrl.sv
// Heater decisions, check timers, blink and report timing.
`default_nettype none

module hgc_ctrl #(
    parameter int SAMPLE_BITS      = 10,
    parameter int REPORT_PERIOD_MS = 5000
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          advance,
    input  wire logic [hgc_pkg::TIME_W-1:0]    now_ms,
    input  wire logic                          test_button,
    input  wire logic [SAMPLE_BITS-1:0]        avg_in,
    input  wire logic [SAMPLE_BITS-1:0]        avg_out,
    input  wire logic [SAMPLE_BITS-1:0]        avg_cab,
    input  wire hgc_pkg::cfg_t                 cfg,
    output hgc_pkg::flags_t                    flags
);

    localparam int CMP_W = (SAMPLE_BITS > hgc_pkg::CODE_W) ? SAMPLE_BITS : hgc_pkg::CODE_W;
    localparam logic [hgc_pkg::TIME_W-1:0] REP_PERIOD = hgc_pkg::TIME_W'(REPORT_PERIOD_MS);

    logic [hgc_pkg::TIME_W-1:0] cab_start_reg,   cab_start_next;
    logic [hgc_pkg::TIME_W-1:0] room_start_reg,  room_start_next;
    logic [hgc_pkg::TIME_W-1:0] rep_start_reg,   rep_start_next;
    logic [hgc_pkg::TIME_W-1:0] blink_start_reg, blink_start_next;
    logic room_on_reg,     room_on_next;
    logic cab_on_reg,      cab_on_next;
    logic error_reg,       error_next;
    logic blink_phase_reg, blink_phase_next;
    logic test_active_reg, test_active_next;
    logic force_reg,       force_next;

    logic cab_exp, room_exp, rep_exp, blink_exp;
    logic cab_due, room_due, report;
    logic cab_want, room_want, err_want;
    logic [CMP_W:0] in_w, out_w, cab_w;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cab_start_reg   <= '0;
            room_start_reg  <= '0;
            rep_start_reg   <= '0;
            blink_start_reg <= '0;
            room_on_reg     <= 1'b0;
            cab_on_reg      <= 1'b0;
            error_reg       <= 1'b0;
            blink_phase_reg <= 1'b0;
            test_active_reg <= 1'b0;
            force_reg       <= 1'b1;
        end else if (advance) begin
            cab_start_reg   <= cab_start_next;
            room_start_reg  <= room_start_next;
            rep_start_reg   <= rep_start_next;
            blink_start_reg <= blink_start_next;
            room_on_reg     <= room_on_next;
            cab_on_reg      <= cab_on_next;
            error_reg       <= error_next;
            blink_phase_reg <= blink_phase_next;
            test_active_reg <= test_active_next;
            force_reg       <= force_next;
        end
    end

    always_comb begin
        // elapsed time is taken modulo 2^32, so wrap of now_ms is harmless
        cab_exp   = (now_ms - cab_start_reg) >= cfg.cab_period_ms;
        room_exp  = (now_ms - room_start_reg) >= cfg.room_period_ms;
        rep_exp   = (now_ms - rep_start_reg) >= REP_PERIOD;
        blink_exp = (now_ms - blink_start_reg) >=
                    hgc_pkg::TIME_W'(cfg.blink_period_ms);

        in_w  = (CMP_W+1)'(avg_in);
        out_w = (CMP_W+1)'(avg_out);
        cab_w = (CMP_W+1)'(avg_cab);

        cab_want  = cab_w <= (CMP_W+1)'(cfg.cab_on_max_code);
        err_want  = (in_w < (CMP_W+1)'(cfg.sensor_low_code)) ||
                    (out_w < (CMP_W+1)'(cfg.sensor_low_code)) ||
                    (in_w > (CMP_W+1)'(cfg.sensor_high_code)) ||
                    (out_w > (CMP_W+1)'(cfg.sensor_high_code));
        // in - out < delta, kept unsigned as in < out + delta
        room_want = (in_w < out_w + (CMP_W+1)'(cfg.room_delta_code)) &&
                    !(in_w > (CMP_W+1)'(cfg.room_limit_code)) && !err_want;

        cab_start_next   = cab_start_reg;
        room_start_next  = room_start_reg;
        rep_start_next   = rep_start_reg;
        blink_start_next = blink_start_reg;
        room_on_next     = room_on_reg;
        cab_on_next      = cab_on_reg;
        error_next       = error_reg;
        blink_phase_next = blink_phase_reg;
        test_active_next = test_active_reg;
        force_next       = force_reg;
        cab_due          = 1'b0;
        room_due         = 1'b0;
        report           = 1'b0;

        priority if (test_button) begin
            test_active_next = 1'b1;
            room_on_next     = 1'b1;
            cab_on_next      = 1'b1;
        end else if (test_active_reg) begin
            // release: heaters off, checks forced on the next beat
            test_active_next = 1'b0;
            room_on_next     = 1'b0;
            cab_on_next      = 1'b0;
            rep_start_next   = now_ms;
            force_next       = 1'b1;
        end else begin
            cab_due    = cab_exp || force_reg;
            room_due   = room_exp || force_reg;
            force_next = 1'b0;
            if (cab_due) begin
                cab_start_next = now_ms;
                cab_on_next    = cab_want;
            end
            if (room_due) begin
                room_start_next = now_ms;
                room_on_next    = room_want;
                error_next      = err_want;
            end
            if (blink_exp) begin
                blink_start_next = now_ms;
                if (error_next) begin
                    blink_phase_next = !blink_phase_reg;
                    cab_on_next      = !blink_phase_reg;
                end
            end
            if (rep_exp) begin
                rep_start_next = now_ms;
            end
            report = rep_exp;
        end

        flags.room_heat    = room_on_next;
        flags.cabinet_heat = cab_on_next;
        flags.sensor_error = error_next;
        flags.report_now   = report;
    end

endmodule

`default_nettype wire
